[hdl/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and codes of the bitmap page frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfa_pkg;

	localparam int WORD_BITS  = 32;
	localparam int WORD_SHIFT = 5;

	localparam logic [15:0] FREE_MAX = 16'hFFFF;

	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_LOCK  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef struct packed {
		logic init_wr;
		logic accept;
		logic prep1;
		logic prep2;
		logic prep3;
		logic scan;
		logic load_out;
	} ctrl_t;

	typedef struct packed {
		logic init_last;
		logic empty;
		logic hit;
		logic last;
		logic out_busy;
	} status_t;

endpackage

`default_nettype wire

[hdl/bpfa_ram.sv]
// ----------------------------------------------------------------------------
// bpfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                                        clk,
	input  wire logic                                        we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                            wdata,
	input  wire logic                                        re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hdl/bpfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bpfa_ctrl
// Command sequencer: clearing pass, operand setup, bitmap scan, response.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_valid,
	output logic                   s_ready,
	input  wire bpfa_pkg::status_t status,
	output bpfa_pkg::ctrl_t        ctrl
);

	import bpfa_pkg::*;

	typedef enum logic [7:0] {
		ST_INIT = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_P1   = 8'b0000_0100,
		ST_P2   = 8'b0000_1000,
		ST_P3   = 8'b0001_0000,
		ST_SCAN = 8'b0010_0000,
		ST_FIN  = 8'b0100_0000,
		ST_RESP = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		ctrl    = '0;
		s_ready = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				ctrl.init_wr = 1'b1;
				if (status.init_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_ready     = 1'b1;
				ctrl.accept = s_valid;
				if (s_valid) begin
					state_d = ST_P1;
				end
			end
			ST_P1: begin
				ctrl.prep1 = 1'b1;
				state_d    = ST_P2;
			end
			ST_P2: begin
				ctrl.prep2 = 1'b1;
				state_d    = ST_P3;
			end
			ST_P3: begin
				ctrl.prep3 = 1'b1;
				state_d    = status.empty ? ST_FIN : ST_SCAN;
			end
			ST_SCAN: begin
				ctrl.scan = 1'b1;
				if (status.hit || status.last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (!status.out_busy) begin
					ctrl.load_out = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

[hdl/bpfa_dpath.sv]
// ----------------------------------------------------------------------------
// bpfa_dpath
// Bitmap RAM, operand setup, word scan with masking, free counter, result.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_dpath #(
	parameter int TOTAL_BLOCKS    = 32768,
	parameter int BLOCK_BYTES     = 4096,
	parameter int RESERVED_BLOCKS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire bpfa_pkg::ctrl_t   ctrl,
	output bpfa_pkg::status_t      status,
	input  wire logic [1:0]        command,
	input  wire logic [31:0]       start_address,
	input  wire logic [31:0]       region_bytes,
	input  wire logic [14:0]       query_block,
	input  wire logic [14:0]       search_start_block,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [31:0]            block_address,
	output logic                   alloc_failed,
	output logic                   occupied,
	output logic                   range_clipped,
	output logic [15:0]            free_blocks
);

	import bpfa_pkg::*;

	localparam int WORDS  = (TOTAL_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PW     = AW + 1;
	localparam int LOG_BB = $clog2(BLOCK_BYTES);
	localparam int RES_C  = (RESERVED_BLOCKS > TOTAL_BLOCKS) ? TOTAL_BLOCKS : RESERVED_BLOCKS;
	localparam int CW     = $clog2(TOTAL_BLOCKS + 1);
	localparam int EW     = 34;

	localparam logic [EW-1:0] N_E       = EW'(TOTAL_BLOCKS);
	localparam logic [EW-1:0] BB_M1     = EW'(BLOCK_BYTES - 1);
	localparam logic [PW-1:0] LAST_WORD = PW'(WORDS - 1);
	localparam logic [4:0]    LAST_BIT  = 5'((TOTAL_BLOCKS - 1) % WORD_BITS);
	localparam logic [CW-1:0] FREE_RST  = CW'(TOTAL_BLOCKS - RES_C);

	function automatic logic [31:0] init_word(input logic [PW-1:0] w);
		logic [31:0] lo;
		logic [31:0] res;
		logic [31:0] pat;
		lo  = 32'(w) << WORD_SHIFT;
		res = 32'(RES_C);
		if (res >= lo + 32'd32) begin
			pat = 32'hFFFF_FFFF;
		end else if (res <= lo) begin
			pat = 32'h0;
		end else begin
			pat = 32'hFFFF_FFFF >> (32'd32 - (res - lo));
		end
		return pat;
	endfunction

	function automatic logic [5:0] popcount32(input logic [31:0] v);
		logic [1:0] l1 [16];
		logic [2:0] l2 [8];
		logic [3:0] l3 [4];
		logic [4:0] l4 [2];
		for (int i = 0; i < 16; i++) begin
			l1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
		end
		for (int i = 0; i < 8; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < 4; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		for (int i = 0; i < 2; i++) begin
			l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
		end
		return {1'b0, l4[0]} + {1'b0, l4[1]};
	endfunction

	function automatic logic [4:0] onehot_index(input logic [31:0] v);
		logic [4:0] idx;
		idx = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) begin
				idx = idx | 5'(i);
			end
		end
		return idx;
	endfunction

	cmd_t          cmd_q;
	logic [31:0]   addr_q;
	logic [31:0]   len_q;
	logic [14:0]   qblk_q;
	logic [14:0]   sstart_q;
	logic [EW-1:0] first_q;
	logic [EW-1:0] cnt_q;
	logic [EW-1:0] end_q;
	logic [PW-1:0] lo_q;
	logic [PW-1:0] hi_q;
	logic [4:0]    lob_q;
	logic [4:0]    hib_q;
	logic [PW-1:0] ptr_q;
	logic          dvld_s1;
	logic [PW-1:0] word_s1;
	logic [5:0]    dec_s2;
	logic [CW-1:0] free_q;
	logic [31:0]   res_addr_q;
	logic          fail_q;
	logic          occ_q;
	logic          clip_q;
	logic          out_vld_q;
	logic [31:0]   out_addr_q;
	logic          out_fail_q;
	logic          out_occ_q;
	logic          out_clip_q;
	logic [15:0]   out_free_q;

	logic [EW-1:0] endc;
	logic [EW-1:0] endm1;
	logic          lock_empty;
	logic          alloc_empty;
	logic          query_oob;
	logic [PW-1:0] lo_d;
	logic [PW-1:0] hi_d;
	logic [4:0]    lob_d;
	logic [4:0]    hib_d;
	logic          empty_d;

	logic          rd_en;
	logic          dv;
	logic [31:0]   rdata;
	logic [31:0]   rmask;
	logic [31:0]   avail;
	logic [31:0]   iso;
	logic [31:0]   newb;
	logic          hit;
	logic          lock_wr;
	logic          we;
	logic [AW-1:0] waddr;
	logic [31:0]   wdata;
	logic [AW+4:0] hit_blk;
	logic [63:0]   hit_addr;
	logic [31:0]   free_ext;

	// Operand setup for the region lock and the scan window.
	always_comb begin
		endc        = (end_q > N_E) ? N_E : end_q;
		endm1       = endc - EW'(1);
		lock_empty  = (cnt_q == '0) || (first_q >= N_E);
		alloc_empty = EW'(sstart_q) >= N_E;
		query_oob   = EW'(qblk_q) >= N_E;
		lo_d        = '0;
		hi_d        = '0;
		lob_d       = '0;
		hib_d       = 5'd31;
		empty_d     = 1'b1;
		unique case (cmd_q)
			CMD_ALLOC: begin
				lo_d    = PW'(sstart_q >> WORD_SHIFT);
				hi_d    = LAST_WORD;
				lob_d   = sstart_q[4:0];
				hib_d   = LAST_BIT;
				empty_d = alloc_empty;
			end
			CMD_LOCK: begin
				lo_d    = PW'(first_q >> WORD_SHIFT);
				hi_d    = PW'(endm1 >> WORD_SHIFT);
				lob_d   = first_q[4:0];
				hib_d   = endm1[4:0];
				empty_d = lock_empty;
			end
			CMD_QUERY: begin
				lo_d    = PW'(qblk_q >> WORD_SHIFT);
				hi_d    = PW'(qblk_q >> WORD_SHIFT);
				lob_d   = qblk_q[4:0];
				empty_d = query_oob;
			end
			default: begin
				empty_d = 1'b1;
			end
		endcase
	end

	// Word scan: the read issued last cycle lands in rdata now.
	always_comb begin
		rd_en   = ctrl.scan && (ptr_q <= hi_q);
		dv      = dvld_s1 && ctrl.scan;
		rmask   = ((word_s1 == lo_q) ? (32'hFFFF_FFFF << lob_q) : 32'hFFFF_FFFF)
			& ((word_s1 == hi_q) ? (32'hFFFF_FFFF >> (5'd31 - hib_q)) : 32'hFFFF_FFFF);
		avail   = ~rdata & rmask;
		iso     = avail & (~avail + 32'd1);
		newb    = avail;
		hit     = dv && (cmd_q == CMD_ALLOC) && (avail != '0);
		lock_wr = dv && (cmd_q == CMD_LOCK);
		hit_blk = {word_s1[AW-1:0], onehot_index(iso)};
		hit_addr = 64'(hit_blk) << LOG_BB;
		we      = 1'b0;
		waddr   = word_s1[AW-1:0];
		wdata   = rdata | rmask;
		if (ctrl.init_wr) begin
			we    = 1'b1;
			waddr = ptr_q[AW-1:0];
			wdata = init_word(ptr_q);
		end else if (hit) begin
			we    = 1'b1;
			wdata = rdata | iso;
		end else if (lock_wr) begin
			we    = 1'b1;
		end
	end

	bpfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_bpfa_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (rd_en),
		.raddr (ptr_q[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			dvld_s1 <= 1'b0;
			dec_s2  <= '0;
			free_q  <= FREE_RST;
			out_vld_q <= 1'b0;
		end else begin
			dvld_s1 <= rd_en;
			if (ctrl.init_wr || rd_en) begin
				ptr_q <= ptr_q + PW'(1);
			end else if (ctrl.prep3) begin
				ptr_q <= lo_d;
			end
			if (hit) begin
				dec_s2 <= 6'd1;
			end else if (lock_wr) begin
				dec_s2 <= popcount32(newb);
			end else begin
				dec_s2 <= '0;
			end
			if (free_q > CW'(dec_s2)) begin
				free_q <= free_q - CW'(dec_s2);
			end else begin
				free_q <= '0;
			end
			if (ctrl.load_out) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		word_s1 <= ptr_q;
		if (ctrl.accept) begin
			cmd_q      <= cmd_t'(command);
			addr_q     <= start_address;
			len_q      <= region_bytes;
			qblk_q     <= query_block;
			sstart_q   <= search_start_block;
			res_addr_q <= '0;
			fail_q     <= (cmd_t'(command) == CMD_ALLOC);
			occ_q      <= 1'b0;
			clip_q     <= 1'b0;
		end
		if (ctrl.prep1) begin
			first_q <= EW'(addr_q >> LOG_BB);
			cnt_q   <= (EW'(len_q) + BB_M1) >> LOG_BB;
		end
		if (ctrl.prep2) begin
			end_q <= first_q + cnt_q;
		end
		if (ctrl.prep3) begin
			lo_q   <= lo_d;
			hi_q   <= hi_d;
			lob_q  <= lob_d;
			hib_q  <= hib_d;
			clip_q <= (cmd_q == CMD_LOCK) && (cnt_q != '0) && (end_q > N_E);
			occ_q  <= (cmd_q == CMD_QUERY) && query_oob;
		end
		if (hit) begin
			res_addr_q <= hit_addr[31:0];
			fail_q     <= 1'b0;
		end
		if (dv && (cmd_q == CMD_QUERY)) begin
			occ_q <= rdata[lob_q];
		end
		if (ctrl.load_out) begin
			out_addr_q <= res_addr_q;
			out_fail_q <= fail_q;
			out_occ_q  <= occ_q;
			out_clip_q <= clip_q;
			out_free_q <= (free_ext > 32'h0000_FFFF) ? FREE_MAX : free_ext[15:0];
		end
	end

	assign free_ext = 32'(free_q);

	assign status.init_last = (ptr_q == LAST_WORD);
	assign status.empty     = empty_d;
	assign status.hit       = hit;
	assign status.last      = dv && (word_s1 == hi_q);
	assign status.out_busy  = out_vld_q && !out_ready;

	assign out_valid     = out_vld_q;
	assign block_address = out_addr_q;
	assign alloc_failed  = out_fail_q;
	assign occupied      = out_occ_q;
	assign range_clipped = out_clip_q;
	assign free_blocks   = out_free_q;

endmodule

`default_nettype wire

[hdl/bitmap_page_frame_allocator_core.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core
// First-fit physical page frame allocator over a one-bit-per-block bitmap.
// ----------------------------------------------------------------------------
// The bitmap lives in a RAM of 32-bit words, one bit per block. After reset a
// clearing pass writes every word once (TOTAL_BLOCKS/32 words, 1024 by default)
// and no command is taken until it ends; the configuration port works during
// it. Each command then takes one item at a time: setup states P1 to P3, bitmap
// words read one after another through the single RAM read port, then FIN and
// RESP to settle the free count and load the result. A query reads one word;
// an allocation reads from the word of search_start_block up to the first word
// with a free block (up to TOTAL_BLOCKS/32 words); a lock reads and rewrites
// each word its region touches. A new command is taken while the previous
// result waits in the output register.
`default_nettype none

module bitmap_page_frame_allocator_core #(
	parameter int TOTAL_BLOCKS    = 32768,
	parameter int BLOCK_BYTES     = 4096,
	parameter int RESERVED_BLOCKS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// command stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// start_address[31:0], region_bytes[63:32], query_block[78:64], pad[79]
	input  wire logic [79:0] s_axis_tdata,
	// command[1:0]
	input  wire logic [1:0]  s_axis_tuser,
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// block_address[31:0], alloc_failed[32], occupied[33], range_clipped[34],
	// free_blocks[50:35], pad[55:51]
	output logic      [55:0] m_axis_tdata
);

	import bpfa_pkg::*;

	localparam logic [2:0]  REG_SEARCH_START = 3'd0;
	localparam logic [14:0] SEARCH_START_RST = 15'd512;

	ctrl_t       ctrl;
	status_t     status;
	logic [14:0] search_start_q;
	logic [31:0] block_address;
	logic        alloc_failed;
	logic        occupied;
	logic        range_clipped;
	logic [15:0] free_blocks;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_SEARCH_START) ? {17'b0, search_start_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			search_start_q <= SEARCH_START_RST;
		end else if (psel && penable && pwrite && (paddr == REG_SEARCH_START)) begin
			search_start_q <= pwdata[14:0];
		end
	end

	bpfa_ctrl u_bpfa_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_axis_tvalid),
		.s_ready (s_axis_tready),
		.status  (status),
		.ctrl    (ctrl)
	);

	bpfa_dpath #(
		.TOTAL_BLOCKS    (TOTAL_BLOCKS),
		.BLOCK_BYTES     (BLOCK_BYTES),
		.RESERVED_BLOCKS (RESERVED_BLOCKS)
	) u_bpfa_dpath (
		.clk                (clk),
		.arst_n             (arst_n),
		.ctrl               (ctrl),
		.status             (status),
		.command            (s_axis_tuser),
		.start_address      (s_axis_tdata[31:0]),
		.region_bytes       (s_axis_tdata[63:32]),
		.query_block        (s_axis_tdata[78:64]),
		.search_start_block (search_start_q),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.block_address      (block_address),
		.alloc_failed       (alloc_failed),
		.occupied           (occupied),
		.range_clipped      (range_clipped),
		.free_blocks        (free_blocks)
	);

	assign m_axis_tdata = {5'b0, free_blocks, range_clipped, occupied, alloc_failed,
		block_address};

endmodule

`default_nettype wire

[hdl/bpfa_checker.sv]
// ----------------------------------------------------------------------------
// bpfa_checker
// Port-level checks of the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [55:0] m_axis_tdata
);

	logic        in_xfer;
	logic        out_xfer;
	logic [1:0]  pend_q;
	logic        seen_q;
	logic [15:0] prev_free_q;

	assign in_xfer  = s_axis_tvalid && s_axis_tready;
	assign out_xfer = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			seen_q      <= 1'b0;
			prev_free_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_xfer} - {1'b0, out_xfer};
			if (out_xfer) begin
				seen_q      <= 1'b1;
				prev_free_q <= m_axis_tdata[50:35];
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_no_extra_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer |-> pend_q != 2'd0)
		else $error("result transfer without a pending command");

	a_in_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |-> pend_q == 2'd0 || pend_q == 2'd1)
		else $error("command taken with two results pending");

	a_free_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q |-> m_axis_tdata[50:35] <= prev_free_q)
		else $error("free block count grew");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32] |->
		m_axis_tdata[31:0] == 32'h0 && !m_axis_tdata[33] && !m_axis_tdata[34])
		else $error("failed allocation carries other result fields");

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/bitmap_page_frame_allocator_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_core_tb
// Self-checking bench for the first-fit page frame allocator. Commands go in
// over the command stream and results come back over the result stream. A
// bit-per-block occupancy map and free count kept here predict each result,
// and every result transfer is compared field by field. A directed table runs
// first. Random phases follow, each under its own search start setting. A
// final phase locks the whole space, so allocations run out.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_core_tb;
	import bpfa_pkg::*;

	localparam int TOTAL_BLOCKS    = 32768;
	localparam int BLOCK_BYTES     = 4096;
	localparam int RESERVED_BLOCKS = 256;

	localparam logic [1:0] CMD_UNUSED        = 2'd3;
	localparam logic [2:0] ADDR_SEARCH_START = 3'd0;

	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS   = 125;
	localparam int HOLD_CYCLES   = 400;
	localparam int DRAIN_CYCLES  = 40;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;

	typedef enum {ROW_CMD, ROW_CFG} row_kind_t;

	typedef struct packed {
		logic [31:0] block_address;
		logic        alloc_failed;
		logic        occupied;
		logic        range_clipped;
		logic [15:0] free_blocks;
	} outcome_t;

	typedef struct {
		row_kind_t   kind;
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [31:0] len;
		logic [14:0] blk;
		bit          typed;
		outcome_t    want;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [79:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [55:0] m_axis_tdata;

	bit          occ_map [TOTAL_BLOCKS];
	int unsigned free_left;
	logic [14:0] search_start;

	outcome_t    pending_outcomes[$];
	stim_row_t   directed_rows[$];
	int          mismatches = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	int          stall_left = 0;
	int          hold_left = 0;
	int          hold_req = 0;
	int          hold_seen = 0;

	bitmap_page_frame_allocator_core #(
		.TOTAL_BLOCKS    (TOTAL_BLOCKS),
		.BLOCK_BYTES     (BLOCK_BYTES),
		.RESERVED_BLOCKS (RESERVED_BLOCKS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void claim_block(longint unsigned b);
		if (b < TOTAL_BLOCKS) begin
			if (!occ_map[int'(b)]) begin
				occ_map[int'(b)] = 1'b1;
				if (free_left > 0)
					free_left--;
			end
		end
	endfunction

	function automatic outcome_t compute_outcome(logic [1:0] cmd, logic [31:0] addr,
			logic [31:0] len, logic [14:0] blk);
		outcome_t        r;
		longint unsigned first;
		longint unsigned count;
		longint unsigned stop;
		bit              found;
		r = '0;
		found = 1'b0;
		case (cmd)
			CMD_ALLOC: begin
				for (int i = int'(search_start); i < TOTAL_BLOCKS; i++) begin
					if (!occ_map[i]) begin
						claim_block(i);
						r.block_address = 32'(longint'(i) * BLOCK_BYTES);
						found = 1'b1;
						break;
					end
				end
				r.alloc_failed = !found;
			end
			CMD_LOCK: begin
				first = longint'(addr) / BLOCK_BYTES;
				count = (longint'(len) + BLOCK_BYTES - 1) / BLOCK_BYTES;
				stop = first + count;
				if (count > 0 && stop > TOTAL_BLOCKS)
					r.range_clipped = 1'b1;
				if (stop > TOTAL_BLOCKS)
					stop = TOTAL_BLOCKS;
				for (longint unsigned b = first; b < stop; b++)
					claim_block(b);
			end
			CMD_QUERY: begin
				r.occupied = (int'(blk) >= TOTAL_BLOCKS) ? 1'b1 : occ_map[int'(blk)];
			end
			default: begin
			end
		endcase
		r.free_blocks = (free_left > 65535) ? 16'hFFFF : 16'(free_left);
		return r;
	endfunction

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %h, got %h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic cmd_row(logic [1:0] cmd, logic [31:0] addr, logic [31:0] len,
			logic [14:0] blk);
		stim_row_t row;
		row.kind = ROW_CMD;
		row.cmd = cmd;
		row.addr = addr;
		row.len = len;
		row.blk = blk;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	task automatic typed_row(logic [1:0] cmd, logic [31:0] addr, logic [31:0] len,
			logic [14:0] blk, logic [31:0] ba, logic fail, logic occ, logic clip,
			logic [15:0] free);
		stim_row_t row;
		row.kind = ROW_CMD;
		row.cmd = cmd;
		row.addr = addr;
		row.len = len;
		row.blk = blk;
		row.typed = 1'b1;
		row.want.block_address = ba;
		row.want.alloc_failed = fail;
		row.want.occupied = occ;
		row.want.range_clipped = clip;
		row.want.free_blocks = free;
		directed_rows.push_back(row);
	endtask

	task automatic cfg_row(logic [14:0] value);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.cmd = CMD_ALLOC;
		row.addr = '0;
		row.len = '0;
		row.blk = value;
		row.typed = 1'b0;
		row.want = '0;
		directed_rows.push_back(row);
	endtask

	// Call at a falling edge; returns at the falling edge after the transfer.
	task automatic send_command(logic [1:0] cmd, logic [31:0] addr, logic [31:0] len,
			logic [14:0] blk, bit typed, outcome_t typed_want);
		int       gap;
		outcome_t predicted;
		gap = idle_on ? $urandom_range(0, 10) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tuser  <= cmd;
		s_axis_tdata  <= {1'b0, blk, len, addr};
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predicted = compute_outcome(cmd, addr, len, blk);
		pending_outcomes.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	// Drain all results, then write and read back the search start register.
	task automatic write_search_start(logic [14:0] value);
		logic [31:0] readback;
		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_SEARCH_START;
		pwdata  <= {17'($urandom), value};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		search_start = value;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		readback = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		check_field("search_start_block", {17'b0, value}, readback);
	endtask

	always @(posedge clk) begin : result_monitor
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			stall_left = idle_on ? $urandom_range(0, 10) : 0;
			if (pending_outcomes.size() == 0) begin
				$error("result transfer with nothing pending: tdata %h", m_axis_tdata);
				mismatches++;
			end else begin
				want = pending_outcomes.pop_front();
				check_field("block_address", want.block_address, m_axis_tdata[31:0]);
				check_field("alloc_failed", 32'(want.alloc_failed), 32'(m_axis_tdata[32]));
				check_field("occupied", 32'(want.occupied), 32'(m_axis_tdata[33]));
				check_field("range_clipped", 32'(want.range_clipped),
					32'(m_axis_tdata[34]));
				check_field("free_blocks", 32'(want.free_blocks), 32'(m_axis_tdata[50:35]));
			end
		end
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		logic [1:0]  cmd;
		logic [31:0] addr;
		logic [31:0] len;
		logic [14:0] blk;
		logic [14:0] start;
		int          pick;
		int          sel;
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = '0;
		for (int i = 0; i < TOTAL_BLOCKS; i++)
			occ_map[i] = (i < RESERVED_BLOCKS);
		free_left = (RESERVED_BLOCKS > TOTAL_BLOCKS) ? 0 : TOTAL_BLOCKS - RESERVED_BLOCKS;
		search_start = 15'd512;

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		typed_row(CMD_QUERY, 32'h0, 32'h0, 15'd0, 32'h0, 1'b0, 1'b1, 1'b0, 16'd32512);
		typed_row(CMD_QUERY, 32'h0, 32'h0, 15'd255, 32'h0, 1'b0, 1'b1, 1'b0, 16'd32512);
		typed_row(CMD_QUERY, 32'h0, 32'h0, 15'd256, 32'h0, 1'b0, 1'b0, 1'b0, 16'd32512);
		typed_row(CMD_QUERY, 32'h0, 32'h0, 15'h7FFF, 32'h0, 1'b0, 1'b0, 1'b0, 16'd32512);
		typed_row(CMD_ALLOC, 32'h0, 32'h0, 15'd0, 32'h0020_0000, 1'b0, 1'b0, 1'b0,
			16'd32511);
		typed_row(CMD_ALLOC, 32'h0, 32'h0, 15'd0, 32'h0020_1000, 1'b0, 1'b0, 1'b0,
			16'd32510);
		typed_row(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF, 32'h0, 1'b0, 1'b0,
			1'b0, 16'd32510);
		typed_row(CMD_LOCK, 32'h0, 32'h0, 15'd0, 32'h0, 1'b0, 1'b0, 1'b0, 16'd32510);
		typed_row(CMD_LOCK, 32'h0, 32'h0010_0000, 15'd0, 32'h0, 1'b0, 1'b0, 1'b0,
			16'd32510);
		typed_row(CMD_LOCK, 32'h0020_0000, 32'h1, 15'd0, 32'h0, 1'b0, 1'b0, 1'b0,
			16'd32510);
		typed_row(CMD_LOCK, 32'h0030_0000, 32'h2001, 15'd0, 32'h0, 1'b0, 1'b0, 1'b0,
			16'd32507);
		typed_row(CMD_LOCK, 32'h07FF_F000, 32'hFFFF_FFFF, 15'd0, 32'h0, 1'b0, 1'b0, 1'b1,
			16'd32506);
		typed_row(CMD_QUERY, 32'h0, 32'h0, 15'h7FFF, 32'h0, 1'b0, 1'b1, 1'b0, 16'd32506);
		typed_row(CMD_LOCK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'd0, 32'h0, 1'b0, 1'b0, 1'b1,
			16'd32506);
		typed_row(CMD_LOCK, 32'hFFFF_F000, 32'h0, 15'd0, 32'h0, 1'b0, 1'b0, 1'b0,
			16'd32506);
		typed_row(CMD_LOCK, 32'h0800_0000, 32'h1, 15'd0, 32'h0, 1'b0, 1'b0, 1'b1,
			16'd32506);
		cmd_row(CMD_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h5555);
		cmd_row(CMD_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 15'h7FFF);
		cmd_row(CMD_LOCK, 32'h0123_4567, 32'h0000_89AB, 15'h2AAA);
		cmd_row(CMD_QUERY, 32'h0, 32'h0, 15'h2AAA);
		cfg_row(15'h7FFF);
		cmd_row(CMD_ALLOC, 32'h0, 32'h0, 15'd0);
		cfg_row(15'd0);
		cmd_row(CMD_ALLOC, 32'h0, 32'h0, 15'd0);
		cmd_row(CMD_ALLOC, 32'h0, 32'h0, 15'd0);
		cmd_row(CMD_QUERY, 32'h0, 32'h0, 15'd256);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_search_start(directed_rows[i].blk);
			end else begin
				send_command(directed_rows[i].cmd, directed_rows[i].addr,
					directed_rows[i].len, directed_rows[i].blk,
					directed_rows[i].typed, directed_rows[i].want);
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: start = 15'd0;
				1: start = 15'h7FFF;
				2: start = 15'd16384;
				3: start = 15'h7FC0;
				default: start = 15'($urandom_range(0, TOTAL_BLOCKS - 1));
			endcase
			write_search_start(start);
			idle_on = (p % 3) != 2;
			// Hold the result side off so the block fills and stalls its input.
			if (p == 1) begin
				idle_on = 1'b0;
				hold_req <= hold_req + 1;
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				addr = $urandom;
				len  = $urandom;
				blk  = 15'($urandom);
				if (pick < 35) begin
					cmd = CMD_ALLOC;
				end else if (pick < 65) begin
					cmd = CMD_QUERY;
					sel = $urandom_range(0, 2);
					if (sel == 1)
						blk = search_start + 15'($urandom_range(0, 63));
					else if (sel == 2)
						blk = 15'($urandom_range(0, 511));
				end else if (pick < 95) begin
					cmd = CMD_LOCK;
					if (pick < 90) begin
						addr = {5'b0, 27'($urandom)};
						len  = $urandom_range(0, 16'hFFFF);
					end else begin
						addr = addr | 32'h0800_0000;
					end
				end else begin
					cmd = CMD_UNUSED;
				end
				send_command(cmd, addr, len, blk, 1'b0, '0);
			end
		end

		// Fill the whole space, then allocations run dry.
		idle_on = 1'b1;
		write_search_start(15'd0);
		send_command(CMD_LOCK, 32'h0, 32'hFFFF_FFFF, 15'd0, 1'b0, '0);
		send_command(CMD_ALLOC, $urandom, $urandom, 15'($urandom), 1'b0, '0);
		send_command(CMD_QUERY, $urandom, $urandom, 15'($urandom), 1'b0, '0);
		send_command(CMD_ALLOC, $urandom, $urandom, 15'($urandom), 1'b0, '0);
		write_search_start(15'h7FFF);
		send_command(CMD_ALLOC, $urandom, $urandom, 15'($urandom), 1'b0, '0);
		send_command(CMD_QUERY, $urandom, $urandom, 15'h7FFF, 1'b0, '0);

		s_axis_tvalid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
